// ----- design/zpc_pkg.sv -----
// ----------------------------------------------------------------------------
// zpc_pkg
// Shared types and constants for the zero-padded 2-D convolution block.
// ----------------------------------------------------------------------------
`default_nettype none

package zpc_pkg;

  localparam int DATA_W         = 32;
  localparam int POS_W          = 6;
  localparam int FUNC_W         = 2;
  localparam int IMG_SIZE_W     = 7;
  localparam int KER_SIZE_W     = 3;
  localparam int CFG_IDX_W      = 1;
  localparam int CFG_DATA_W     = 7;
  localparam int CW             = 12;

  localparam int DEF_MAX_IMAGE  = 64;
  localparam int DEF_MAX_KERNEL = 7;

  localparam logic [FUNC_W-1:0] FUNC_KERNEL = 2'd0;
  localparam logic [FUNC_W-1:0] FUNC_IMAGE  = 2'd1;
  localparam logic [FUNC_W-1:0] FUNC_CONV   = 2'd2;

  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_SIZE  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_KERNEL_SIZE = 1'b1;

  localparam logic [IMG_SIZE_W-1:0] IMG_SIZE_RST = 7'd64;
  localparam logic [KER_SIZE_W-1:0] KER_SIZE_RST = 3'd3;

  typedef struct packed {
    logic issue;
    logic hit;
    logic first;
    logic last;
  } tap_ctl_t;

endpackage

`default_nettype wire

// ----- design/zpc_ram.sv -----
// ----------------------------------------------------------------------------
// zpc_ram
// Single write port, single read port memory with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module zpc_ram #(
  parameter int DEPTH = 64,
  parameter int WIDTH = 32,
  parameter int AW    = 6
) (
  input  wire logic             clk,
  input  wire logic             wr_en,
  input  wire logic [AW-1:0]    wr_addr,
  input  wire logic [WIDTH-1:0] wr_data,
  input  wire logic [AW-1:0]    rd_addr,
  output logic      [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    rd_data_r <= mem[rd_addr];
  end

  assign rd_data = rd_data_r;

endmodule

`default_nettype wire

// ----- design/zpc_mac.sv -----
// ----------------------------------------------------------------------------
// zpc_mac
// Shared multiply-accumulate unit: one tap a cycle, registered product,
// wrapping 32-bit accumulator and result strobe.
// ----------------------------------------------------------------------------
`default_nettype none

module zpc_mac
  import zpc_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire tap_ctl_t          tap,
  input  wire logic [DATA_W-1:0] pix,
  input  wire logic [DATA_W-1:0] coef,
  output logic                   fin,
  output logic                   out_valid,
  output logic [DATA_W-1:0]      out_sum
);

  tap_ctl_t          ctl_d1_r, ctl_d2_r;
  logic [DATA_W-1:0] prod_r, prod_nxt;
  logic [DATA_W-1:0] acc_r, acc_nxt;
  logic [DATA_W-1:0] sum_r;
  logic              out_valid_r;

  always_comb begin
    prod_nxt = ctl_d1_r.hit ? DATA_W'(pix * coef) : '0;
    acc_nxt  = ctl_d2_r.first ? prod_r : DATA_W'(acc_r + prod_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl_d1_r    <= '0;
      ctl_d2_r    <= '0;
      out_valid_r <= 1'b0;
    end else begin
      ctl_d1_r    <= tap;
      ctl_d2_r    <= ctl_d1_r;
      out_valid_r <= ctl_d2_r.issue && ctl_d2_r.last;
    end
  end

  always_ff @(posedge clk) begin
    prod_r <= prod_nxt;
    if (ctl_d2_r.issue) begin
      acc_r <= acc_nxt;
    end
    if (ctl_d2_r.issue && ctl_d2_r.last) begin
      sum_r <= acc_nxt;
    end
  end

  assign fin       = ctl_d2_r.issue && ctl_d2_r.last;
  assign out_valid = out_valid_r;
  assign out_sum   = sum_r;

`ifndef SYNTHESIS
  a_strobe_follows_last: assert property (@(posedge clk) disable iff (!rst_n)
    fin |=> out_valid)
    else $error("result strobe missing after last tap");
  a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (ctl_d1_r.issue && !ctl_d1_r.hit) |=> (prod_r == '0))
    else $error("padding tap gave a non-zero product");
  a_first_before_last: assert property (@(posedge clk) disable iff (!rst_n)
    (ctl_d1_r.issue && ctl_d1_r.last && !ctl_d1_r.first) |-> ctl_d2_r.issue)
    else $error("tap stream broken before last tap");
`endif

endmodule

`default_nettype wire

// ----- design/zpc_seq.sv -----
// ----------------------------------------------------------------------------
// zpc_seq
// Query sequencer: latches the position and sizes, walks the kernel window
// one tap a cycle and drives the memory read addresses.
// ----------------------------------------------------------------------------
`default_nettype none

module zpc_seq
  import zpc_pkg::*;
#(
  parameter int MAX_IMAGE  = DEF_MAX_IMAGE,
  parameter int MAX_KERNEL = DEF_MAX_KERNEL,
  parameter int IA_W       = 12,
  parameter int KA_W       = 6
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  go,
  input  wire logic [POS_W-1:0]      q_row,
  input  wire logic [POS_W-1:0]      q_col,
  input  wire logic [IMG_SIZE_W-1:0] image_size,
  input  wire logic [KER_SIZE_W-1:0] kernel_size,
  input  wire logic                  fin,
  output logic                       busy,
  output logic [POS_W-1:0]           out_row,
  output logic [POS_W-1:0]           out_col,
  output tap_ctl_t                   tap,
  output logic [IA_W-1:0]            img_addr,
  output logic [KA_W-1:0]            ker_addr
);

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_RUN   = 2'd1;
  localparam logic [1:0] ST_DRAIN = 2'd2;

  localparam logic [CW-1:0] MAXI_C = CW'(MAX_IMAGE);
  localparam logic [3:0]    MAXK_C = 4'(MAX_KERNEL);

  logic [1:0]            state_r, state_nxt;
  logic [POS_W-1:0]      q_row_r, q_col_r;
  logic [CW-1:0]         isz_r, isz_nxt;
  logic [KER_SIZE_W-1:0] ksz_r, ksz_nxt;
  logic [KER_SIZE_W-1:0] i_r, j_r, i_nxt, j_nxt;
  logic [KER_SIZE_W-1:0] half, kmax;
  logic [CW-1:0]         ir, ic;
  logic                  row_in, col_in, last;

  always_comb begin
    isz_nxt = (CW'(image_size) > MAXI_C) ? MAXI_C : CW'(image_size);
    ksz_nxt = ({1'b0, kernel_size} > MAXK_C) ? KER_SIZE_W'(MAX_KERNEL) : kernel_size;
    half    = ksz_r >> 1;
    kmax    = (ksz_r == '0) ? '0 : KER_SIZE_W'(ksz_r - 3'd1);
    ir      = CW'(CW'(q_row_r) + CW'(i_r) - CW'(half));
    ic      = CW'(CW'(q_col_r) + CW'(j_r) - CW'(half));
    row_in  = !ir[CW-1] && (ir < isz_r);
    col_in  = !ic[CW-1] && (ic < isz_r);
    last    = (i_r == kmax) && (j_r == kmax);
  end

  always_comb begin
    tap.issue = (state_r == ST_RUN);
    tap.hit   = (state_r == ST_RUN) && (ksz_r != '0) && row_in && col_in;
    tap.first = (i_r == '0) && (j_r == '0);
    tap.last  = last;
    img_addr  = IA_W'(ir * MAX_IMAGE + ic);
    ker_addr  = KA_W'(i_r * MAX_KERNEL + j_r);
  end

  always_comb begin
    state_nxt = state_r;
    i_nxt     = i_r;
    j_nxt     = j_r;
    unique case (state_r)
      ST_IDLE: begin
        if (go) begin
          state_nxt = ST_RUN;
          i_nxt     = '0;
          j_nxt     = '0;
        end
      end
      ST_RUN: begin
        if (last) begin
          state_nxt = ST_DRAIN;
        end else if (j_r == kmax) begin
          j_nxt = '0;
          i_nxt = KER_SIZE_W'(i_r + 3'd1);
        end else begin
          j_nxt = KER_SIZE_W'(j_r + 3'd1);
        end
      end
      ST_DRAIN: begin
        if (fin) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    i_r <= i_nxt;
    j_r <= j_nxt;
    if (go && state_r == ST_IDLE) begin
      q_row_r <= q_row;
      q_col_r <= q_col;
      isz_r   <= isz_nxt;
      ksz_r   <= ksz_nxt;
    end
  end

  assign busy    = (state_r != ST_IDLE);
  assign out_row = q_row_r;
  assign out_col = q_col_r;

`ifndef SYNTHESIS
  a_fin_in_drain: assert property (@(posedge clk) disable iff (!rst_n)
    fin |-> (state_r == ST_DRAIN))
    else $error("accumulator finished outside drain");
  a_go_starts_run: assert property (@(posedge clk) disable iff (!rst_n)
    (go && !busy) |=> (state_r == ST_RUN))
    else $error("query accepted but window walk not started");
  a_hit_needs_issue: assert property (@(posedge clk) disable iff (!rst_n)
    tap.hit |-> tap.issue)
    else $error("tap hit flagged outside window walk");
`endif

endmodule

`default_nettype wire

// ----- design/zero_padded_2d_convolution.sv -----
// ----------------------------------------------------------------------------
// zero_padded_2d_convolution
// Zero-padded 2-D convolution of a stored square image with a stored square
// kernel, one multiply-accumulate per cycle while a query walks its window.
// ----------------------------------------------------------------------------
// Kernel and pixel writes never raise busy. A compute query holds busy while
// it walks the K*K window taps, K being the kernel side in use (one empty tap
// still runs when K is zero), and while the last tap drains to the
// accumulator; out_valid pulses for one cycle as busy falls and out_row,
// out_col and out_conv_sum are valid in that cycle only, as the receiver
// cannot stall. The single shared 32x32 multiplier is fed one window tap a
// cycle from the image and kernel memories; their registered reads and the
// product register lie between each tap and the accumulator.
// Entries must be written before a query reads them; no clearing pass runs.
`default_nettype none

module zero_padded_2d_convolution
  import zpc_pkg::*;
#(
  parameter int MAX_IMAGE  = DEF_MAX_IMAGE,
  parameter int MAX_KERNEL = DEF_MAX_KERNEL
) (
  input  wire logic                     clk,
  input  wire logic                     rst_n,
  input  wire logic                     start,
  output logic                          busy,
  input  wire logic [FUNC_W-1:0]        in_func,
  input  wire logic [POS_W-1:0]         in_row,
  input  wire logic [POS_W-1:0]         in_col,
  input  wire logic signed [DATA_W-1:0] in_value,
  output logic                          out_valid,
  output logic [POS_W-1:0]              out_row,
  output logic [POS_W-1:0]              out_col,
  output logic signed [DATA_W-1:0]      out_conv_sum,
  input  wire logic                     cfg_we,
  input  wire logic [CFG_IDX_W-1:0]     cfg_index,
  input  wire logic [CFG_DATA_W-1:0]    cfg_wdata
);

  localparam int IMG_DEPTH = MAX_IMAGE * MAX_IMAGE;
  localparam int KER_DEPTH = MAX_KERNEL * MAX_KERNEL;
  localparam int IA_W      = (IMG_DEPTH > 1) ? $clog2(IMG_DEPTH) : 1;
  localparam int KA_W      = (KER_DEPTH > 1) ? $clog2(KER_DEPTH) : 1;

  logic [IMG_SIZE_W-1:0] image_size_r;
  logic [KER_SIZE_W-1:0] kernel_size_r;

  logic              accept, img_we, ker_we, go, fin;
  logic [IA_W-1:0]   img_wr_addr, img_rd_addr;
  logic [KA_W-1:0]   ker_wr_addr, ker_rd_addr;
  logic [DATA_W-1:0] pix, coef, sum;
  tap_ctl_t          tap;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      image_size_r  <= IMG_SIZE_RST;
      kernel_size_r <= KER_SIZE_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_IMAGE_SIZE:  image_size_r  <= cfg_wdata;
        REG_KERNEL_SIZE: kernel_size_r <= cfg_wdata[KER_SIZE_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    accept      = start && !busy;
    img_we      = accept && (in_func == FUNC_IMAGE) &&
                  (CW'(in_row) < CW'(MAX_IMAGE)) && (CW'(in_col) < CW'(MAX_IMAGE));
    ker_we      = accept && (in_func == FUNC_KERNEL) &&
                  (CW'(in_row) < CW'(MAX_KERNEL)) && (CW'(in_col) < CW'(MAX_KERNEL));
    go          = accept && (in_func == FUNC_CONV);
    img_wr_addr = IA_W'(in_row * MAX_IMAGE + in_col);
    ker_wr_addr = KA_W'(in_row * MAX_KERNEL + in_col);
  end

  zpc_ram #(
    .DEPTH (IMG_DEPTH),
    .WIDTH (DATA_W),
    .AW    (IA_W)
  ) u_img_ram (
    .clk     (clk),
    .wr_en   (img_we),
    .wr_addr (img_wr_addr),
    .wr_data (in_value),
    .rd_addr (img_rd_addr),
    .rd_data (pix)
  );

  zpc_ram #(
    .DEPTH (KER_DEPTH),
    .WIDTH (DATA_W),
    .AW    (KA_W)
  ) u_ker_ram (
    .clk     (clk),
    .wr_en   (ker_we),
    .wr_addr (ker_wr_addr),
    .wr_data (in_value),
    .rd_addr (ker_rd_addr),
    .rd_data (coef)
  );

  zpc_seq #(
    .MAX_IMAGE  (MAX_IMAGE),
    .MAX_KERNEL (MAX_KERNEL),
    .IA_W       (IA_W),
    .KA_W       (KA_W)
  ) u_seq (
    .clk         (clk),
    .rst_n       (rst_n),
    .go          (go),
    .q_row       (in_row),
    .q_col       (in_col),
    .image_size  (image_size_r),
    .kernel_size (kernel_size_r),
    .fin         (fin),
    .busy        (busy),
    .out_row     (out_row),
    .out_col     (out_col),
    .tap         (tap),
    .img_addr    (img_rd_addr),
    .ker_addr    (ker_rd_addr)
  );

  zpc_mac u_mac (
    .clk       (clk),
    .rst_n     (rst_n),
    .tap       (tap),
    .pix       (pix),
    .coef      (coef),
    .fin       (fin),
    .out_valid (out_valid),
    .out_sum   (sum)
  );

  assign out_conv_sum = $signed(sum);

endmodule

`default_nettype wire
